>>> src/bamop_pkg.sv
// ----------------------------------------------------------------------------
// bamop_pkg
// Shared types, constants and the Q2.30 multiply used by the lattice pricer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bamop_pkg;

  // Fixed-point constants (Q2.30: 1.0 = 2^30)
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
  localparam logic [47:0] SAT48    = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STEP_COUNT = 3'd0,
    REG_UP_FACTOR  = 3'd1,
    REG_DOWN       = 3'd2,
    REG_PROB_UP    = 3'd3,
    REG_DISCOUNT   = 3'd4
  } cfg_reg_t;

  // Control broadcast from the sequencer to every lattice cell
  typedef struct packed {
    logic load;    // shift price factors in from the generator
    logic commit;  // end of a level: store node value, shift down power
    logic leaf;    // current level is the leaf level (no continuation)
  } cell_ctl_t;

  // floor(a * b / 2^30) for a < 2^48, b < 2^32
  function automatic logic [50:0] mul_q30(input logic [47:0] a, input logic [31:0] b);
    logic [49:0] hi_p;
    logic [61:0] lo_p;
    hi_p = 50'(a[47:30]) * 50'(b);
    lo_p = 62'(a[29:0]) * 62'(b);
    return 51'(hi_p) + 51'(lo_p[61:30]);
  endfunction

endpackage

>>> src/bamop_gen.sv
// ----------------------------------------------------------------------------
// bamop_gen
// Power generator: produces S*u^j (48-bit, saturating) and d^k (Q2.30), one
// step per cycle while step is high, to be shifted into the lattice cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bamop_gen
  import bamop_pkg::*;
(
  input  logic        clk,
  input  logic        start,      // load spot, restart down power at 1.0
  input  logic        step,       // advance the spot power
  input  logic        dpow_en,    // advance the down power
  input  logic [31:0] spot,
  input  logic [31:0] up_factor,
  input  logic [30:0] down_q,     // clamped down factor
  output logic [47:0] sup_feed,
  output logic [30:0] dpow_feed
);

  logic [47:0] sreg;
  logic [30:0] dreg;
  logic [50:0] s_mul;
  logic [50:0] d_mul;
  logic [47:0] sreg_next;
  logic [30:0] dreg_next;

  // One truncating Q2.30 multiply per power
  always_comb begin
    s_mul     = mul_q30(sreg, up_factor);
    d_mul     = mul_q30({17'd0, dreg}, {1'b0, down_q});
    sreg_next = (s_mul > 51'(SAT48)) ? SAT48 : s_mul[47:0];
    dreg_next = d_mul[30:0];
  end

  // Load, hold or advance the running powers
  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= {16'd0, spot};
      dreg <= ONE_Q30;
    end else if (step) begin
      sreg <= sreg_next;
      if (dpow_en) begin
        dreg <= dreg_next;
      end
    end
  end

  assign sup_feed  = sreg;
  assign dpow_feed = dreg;

endmodule

>>> src/bamop_cell.sv
// ----------------------------------------------------------------------------
// bamop_cell
// One lattice node: holds S*u^j, the current down power and the node value,
// and computes one backward-induction step in product, price, value stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bamop_cell
  import bamop_pkg::*;
(
  input  logic        clk,
  input  cell_ctl_t   ctl,
  input  logic        is_call,
  input  logic [31:0] strike,
  input  logic [30:0] prob_p,
  input  logic [30:0] prob_q,
  input  logic [30:0] disc,
  input  logic [47:0] sup_in,      // from upper neighbor during load
  input  logic [30:0] dpow_lo_in,  // from lower neighbor during load
  input  logic [30:0] dpow_hi_in,  // from upper neighbor at level end
  input  logic [31:0] v_hi_in,     // value of the up child
  output logic [47:0] sup_out,
  output logic [30:0] dpow_out,
  output logic [31:0] v_out
);

  logic [47:0] sup;
  logic [30:0] dpow;
  logic [31:0] v;

  // product stage: partial products
  logic [48:0] pa;
  logic [60:0] pb;
  logic [62:0] cp;
  logic [62:0] cq;
  // price stage: node price and discounted sum
  logic [31:0] price;
  logic [62:0] cd;
  logic [50:0] price_sum;
  logic [63:0] cont_sum;
  // value stage: exercise vs continuation
  logic [31:0] ex;
  logic [31:0] cont;
  logic [31:0] v_next;

  // Products of price factors and child values
  always_ff @(posedge clk) begin
    pa <= 49'(sup[47:30]) * 49'(dpow);
    pb <= 61'(sup[29:0]) * 61'(dpow);
    cp <= 63'(prob_p) * 63'(v_hi_in);
    cq <= 63'(prob_q) * 63'(v);
  end

  always_comb begin
    price_sum = 51'(pa) + 51'(pb[60:30]);
    cont_sum  = 64'(cp) + 64'(cq);
  end

  // Saturate the node price, apply the discount
  always_ff @(posedge clk) begin
    price <= (price_sum > 51'(MAX32)) ? MAX32 : price_sum[31:0];
    cd    <= 63'(cont_sum[61:30]) * 63'(disc);
  end

  // Pick the larger of early exercise and continuation (exercise at the leaf)
  always_comb begin
    if (is_call) begin
      ex = (price > strike) ? price - strike : '0;
    end else begin
      ex = (strike > price) ? strike - price : '0;
    end
    cont = cd[62] ? MAX32 : cd[61:30];
    if (ctl.leaf) begin
      v_next = ex;
    end else begin
      v_next = (cont > ex) ? cont : ex;
    end
  end

  // Shift factors in on load, store value and shift down power per level
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sup  <= sup_in;
      dpow <= dpow_lo_in;
    end else if (ctl.commit) begin
      dpow <= dpow_hi_in;
    end
    if (ctl.commit) begin
      v <= v_next;
    end
  end

  assign sup_out  = sup;
  assign dpow_out = dpow;
  assign v_out    = v;

endmodule

>>> src/binomial_american_option_pricer.sv
// ----------------------------------------------------------------------------
// binomial_american_option_pricer
// Sequence: the power generator shifts factors into all MAX_STEPS + 1 cells,
//   then each of the n + 1 lattice levels (n = step_count clamped to MAX_STEPS)
//   runs phases A, B and C; the root value then goes to the output register.
// A new option is taken only in the idle state, so options are spaced by the
//   shift-in of the cell row and the multiply path of each level.
// Reset (rst, synchronous): sequencer idle, output empty, configuration registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binomial_american_option_pricer
  import bamop_pkg::*;
#(
  parameter int MAX_STEPS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input options
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] spot, [63:32] strike
  input  logic        s_axis_tuser,   // [0] is_call
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] option_value
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NW = $clog2(MAX_STEPS + 1);
  localparam logic [NW-1:0] LAST = NW'(MAX_STEPS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_PH_A = 6'b000100,
    ST_PH_B = 6'b001000,
    ST_PH_C = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [8:0]  step_count;
  logic [31:0] up_factor;
  logic [30:0] down_factor;
  logic [30:0] prob_up;
  logic [30:0] discount;

  // clamped working values
  logic [NW-1:0] n_steps;
  logic [NW-1:0] pad;
  logic [30:0]   down_q;
  logic [30:0]   prob_p;
  logic [30:0]   prob_q;

  // sequencer
  logic [NW-1:0] ld_cnt;
  logic [NW-1:0] rem;
  logic          leaf;
  logic          item_call;
  logic [31:0]   item_strike;
  logic          accept;
  cell_ctl_t     ctl;

  // output register
  logic          out_valid;
  logic [31:0]   out_data;

  // cell row
  logic [47:0] sup_bus  [0:MAX_STEPS+1];
  logic [30:0] dpow_bus [0:MAX_STEPS+2];
  logic [31:0] v_bus    [0:MAX_STEPS+1];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= 9'd1;
      up_factor   <= 32'(ONE_Q30);
      down_factor <= ONE_Q30;
      prob_up     <= HALF_Q30;
      discount    <= ONE_Q30;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STEP_COUNT: step_count  <= cfg_data[8:0];
        REG_UP_FACTOR:  up_factor   <= cfg_data;
        REG_DOWN:       down_factor <= cfg_data[30:0];
        REG_PROB_UP:    prob_up     <= cfg_data[30:0];
        REG_DISCOUNT:   discount    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Clamp step count, down factor and probability
  always_comb begin
    n_steps = (32'(step_count) > 32'(MAX_STEPS)) ? LAST : NW'(step_count);
    pad     = LAST - n_steps;
    down_q  = (down_factor > ONE_Q30) ? ONE_Q30 : down_factor;
    prob_p  = (prob_up > ONE_Q30) ? ONE_Q30 : prob_up;
    prob_q  = ONE_Q30 - prob_p;
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_LOAD;
      ST_LOAD: if (ld_cnt == LAST) state_next = ST_PH_A;
      ST_PH_A: state_next = ST_PH_B;
      ST_PH_B: state_next = ST_PH_C;
      ST_PH_C: begin
        if (leaf) begin
          state_next = (rem == '0) ? ST_DONE : ST_PH_A;
        end else begin
          state_next = (rem == NW'(1)) ? ST_DONE : ST_PH_A;
        end
      end
      ST_DONE: if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers: load counter, remaining levels, leaf flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ld_cnt <= '0;
      rem    <= '0;
      leaf   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        if (ld_cnt == LAST) begin
          ld_cnt <= '0;
          rem    <= n_steps;
          leaf   <= 1'b1;
        end else begin
          ld_cnt <= ld_cnt + NW'(1);
        end
      end
      if (state == ST_PH_C) begin
        if (leaf) begin
          leaf <= 1'b0;
        end else begin
          rem <= rem - NW'(1);
        end
      end
    end
  end

  // Hold the option kind and strike for the whole item
  always_ff @(posedge clk) begin
    if (accept) begin
      item_call   <= s_axis_tuser;
      item_strike <= s_axis_tdata[63:32];
    end
  end

  // Output register: take the root value, drop it once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
      out_data <= v_bus[0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Broadcast cell control
  always_comb begin
    ctl.load   = (state == ST_LOAD);
    ctl.commit = (state == ST_PH_C);
    ctl.leaf   = leaf;
  end

  // Power generator feeding the row
  bamop_gen u_gen (
    .clk       (clk),
    .start     (accept),
    .step      (state == ST_LOAD),
    .dpow_en   (ld_cnt >= pad),
    .spot      (s_axis_tdata[31:0]),
    .up_factor (up_factor),
    .down_q    (down_q),
    .sup_feed  (sup_bus[MAX_STEPS+1]),
    .dpow_feed (dpow_bus[0])
  );

  // Row ends: nothing above the top cell
  assign dpow_bus[MAX_STEPS+2] = '0;
  assign v_bus[MAX_STEPS+1]    = '0;

  // Row of lattice cells: node j lives in cell j, root in cell 0
  for (genvar j = 0; j <= MAX_STEPS; j++) begin : g_cell
    bamop_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .is_call    (item_call),
      .strike     (item_strike),
      .prob_p     (prob_p),
      .prob_q     (prob_q),
      .disc       (discount),
      .sup_in     (sup_bus[j+1]),
      .dpow_lo_in (dpow_bus[j]),
      .dpow_hi_in (dpow_bus[j+2]),
      .v_hi_in    (v_bus[j+1]),
      .sup_out    (sup_bus[j]),
      .dpow_out   (dpow_bus[j+1]),
      .v_out      (v_bus[j])
    );
  end

  // Checks
  a_done_no_levels_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> rem == '0)
    else $error("result stage reached with lattice levels left");

  a_load_count_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> ld_cnt == '0)
    else $error("load counter not cleared outside the load phase");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_DONE))
    else $error("result presented without a finished lattice");

endmodule
